FILE: sv/ray_box_nearest_hit_macros.svh
`ifndef RAY_BOX_NEAREST_HIT_MACROS_SVH
`define RAY_BOX_NEAREST_HIT_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define RBNH_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next one.
`define RBNH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Consequent must hold in the cycle after reset is seen.
`define RBNH_ASSERT_AFTER_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

FILE: sv/rbnh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rbnh_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ID_BITS   = 20;
  localparam int VAL_W     = 32;
  localparam int SIZE_W    = 31;
  // Slab bound minus origin needs 34 signed bits; DIFF_W keeps 35.
  localparam int DIFF_W    = 35;
  localparam int NUM_W     = DIFF_W + FRAC_BITS;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int IN_DATA_W  = 216;
  localparam int OUT_DATA_W = 56;

  localparam logic signed [VAL_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam longint LIMIT_FULL = 64'sd10000 * (64'sd1 <<< FRAC_BITS);
  localparam logic signed [VAL_W-1:0] LIMIT =
      (LIMIT_FULL > 64'sd2147483647) ? S32_MAX : VAL_W'(LIMIT_FULL);

  // Configuration register indexes.
  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] CFG_DIR_X    = 3'd3;
  localparam logic [2:0] CFG_DIR_Y    = 3'd4;
  localparam logic [2:0] CFG_DIR_Z    = 3'd5;

  // One classified box as handed from the front to the back.
  typedef struct packed {
    logic [2:0][DIFF_W-1:0] diff_lo;
    logic [2:0][DIFF_W-1:0] diff_hi;
    logic [ID_BITS-1:0]     box_id;
    logic                   last_box;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_AXIS,
    S_WAIT,
    S_DONE
  } back_state_t;

endpackage
`default_nettype wire

FILE: sv/rbnh_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rbnh_front (
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [rbnh_pkg::IN_DATA_W-1:0]    s_tdata,
  input  wire logic                              s_tlast,
  input  wire logic [2:0][rbnh_pkg::VAL_W-1:0]   origin,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output rbnh_pkg::entry_t                       q_entry
);

  logic signed [rbnh_pkg::VAL_W-1:0]  center [3];
  logic        [rbnh_pkg::SIZE_W-1:0] size   [3];

  // Unpack the request fields.
  assign center[0] = s_tdata[31:0];
  assign center[1] = s_tdata[63:32];
  assign center[2] = s_tdata[95:64];
  assign size[0]   = s_tdata[126:96];
  assign size[1]   = s_tdata[157:127];
  assign size[2]   = s_tdata[188:158];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // Slab bounds relative to the ray origin, kept exact.
  always_comb begin
    logic signed [rbnh_pkg::DIFF_W-1:0] half;
    logic signed [rbnh_pkg::DIFF_W-1:0] ctr;
    logic signed [rbnh_pkg::DIFF_W-1:0] org;
    q_entry = '0;
    for (int a = 0; a < 3; a++) begin
      half = rbnh_pkg::DIFF_W'(size[a] >> 1);
      ctr  = rbnh_pkg::DIFF_W'(center[a]);
      org  = rbnh_pkg::DIFF_W'($signed(origin[a]));
      q_entry.diff_lo[a] = ctr - half - org;
      q_entry.diff_hi[a] = ctr + half - org;
    end
    q_entry.box_id   = s_tdata[208:189];
    q_entry.last_box = s_tlast;
  end

endmodule
`default_nettype wire

FILE: sv/rbnh_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rbnh_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire rbnh_pkg::entry_t push_entry,
  input  wire logic             pop,
  output rbnh_pkg::entry_t      head,
  output logic                  full,
  output logic                  empty
);

  rbnh_pkg::entry_t                  slots [rbnh_pkg::QDEPTH];
  logic [rbnh_pkg::QPTR_W-1:0]       wr_ptr;
  logic [rbnh_pkg::QPTR_W-1:0]       rd_ptr;
  logic [rbnh_pkg::QPTR_W:0]         count;

  assign full  = (count == (rbnh_pkg::QPTR_W + 1)'(rbnh_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule
`default_nettype wire

FILE: sv/rbnh_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rbnh_div (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic signed [rbnh_pkg::NUM_W-1:0]   num,
  input  wire logic signed [rbnh_pkg::VAL_W-1:0]   den,
  output logic                                     done,
  output logic signed [rbnh_pkg::VAL_W-1:0]        quot
);

  logic                         busy;
  logic [4:0]                   cnt;
  logic                         neg;
  logic                         ovf;
  logic [31:0]                  dmag;
  logic [31:0]                  rem;
  logic [31:0]                  nlow;
  logic [31:0]                  qmag;
  logic [rbnh_pkg::NUM_W-1:0]   nmag_in;
  logic [31:0]                  dmag_in;
  logic [32:0]                  rem_sh;
  logic                         ge;

  assign nmag_in = num[rbnh_pkg::NUM_W-1] ? rbnh_pkg::NUM_W'(-num) : rbnh_pkg::NUM_W'(num);
  assign dmag_in = den[31] ? 32'(-den) : 32'(den);
  assign rem_sh  = {rem, nlow[31]};
  assign ge      = rem_sh >= {1'b0, dmag};

  // Restoring division, one quotient bit a cycle; a quotient that cannot
  // fit in 32 bits is caught up front and saturated.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg  <= num[rbnh_pkg::NUM_W-1] ^ den[31];
        dmag <= dmag_in;
        ovf  <= 64'(nmag_in) >= {dmag_in, 32'd0};
        rem  <= 32'(nmag_in >> 32);
        nlow <= nmag_in[31:0];
        qmag <= '0;
        cnt  <= 5'd31;
        if (64'(nmag_in) >= {dmag_in, 32'd0}) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= ge ? 32'(rem_sh - {1'b0, dmag}) : rem_sh[31:0];
        nlow <= {nlow[30:0], 1'b0};
        qmag <= {qmag[30:0], ge};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Sign and saturation of the finished quotient.
  always_comb begin
    if (ovf) begin
      quot = neg ? rbnh_pkg::S32_MIN : rbnh_pkg::S32_MAX;
    end else if (neg) begin
      quot = (qmag > 32'h8000_0000) ? rbnh_pkg::S32_MIN : 32'(-qmag);
    end else begin
      quot = (qmag > 32'h7fff_ffff) ? rbnh_pkg::S32_MAX : qmag;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rbnh_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rbnh_back (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [2:0][rbnh_pkg::VAL_W-1:0]       dir,
  input  wire logic                                  q_empty,
  input  wire rbnh_pkg::entry_t                      q_head,
  output logic                                       q_pop,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic [rbnh_pkg::OUT_DATA_W-1:0]            m_tdata,
  output logic                                       m_tuser
);

  rbnh_pkg::back_state_t state, state_next;
  rbnh_pkg::entry_t      e, e_next;
  logic [1:0]            axis, axis_next;
  logic                  side, side_next;
  logic                  miss, miss_next;
  logic signed [31:0]    tmin, tmin_next;
  logic signed [31:0]    tmax, tmax_next;
  logic signed [31:0]    t1, t1_next;
  logic signed [31:0]    best_dist, best_dist_next;
  logic [rbnh_pkg::ID_BITS-1:0] best_id, best_id_next;
  logic                  found, found_next;
  logic                  emit;
  logic                  out_hit;
  logic [rbnh_pkg::ID_BITS-1:0] out_id;
  logic signed [31:0]    out_dist;

  logic                  div_start;
  logic                  div_done;
  logic signed [31:0]    div_q;
  logic signed [rbnh_pkg::DIFF_W-1:0] lo_cur;
  logic signed [rbnh_pkg::DIFF_W-1:0] hi_cur;
  logic signed [31:0]    dir_cur;
  logic signed [rbnh_pkg::NUM_W-1:0]  div_num;

  assign lo_cur  = e.diff_lo[axis];
  assign hi_cur  = e.diff_hi[axis];
  assign dir_cur = dir[axis];
  assign div_num = {(side ? hi_cur : lo_cur), {rbnh_pkg::FRAC_BITS{1'b0}}};

  rbnh_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dir_cur),
    .done  (div_done),
    .quot  (div_q)
  );

  // State register and control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rbnh_pkg::S_IDLE;
      found     <= 1'b0;
      best_dist <= rbnh_pkg::LIMIT;
      best_id   <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      found     <= found_next;
      best_dist <= best_dist_next;
      best_id   <= best_id_next;
      if (emit)          m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Working registers of the box in flight, and the result register.
  always_ff @(posedge clk) begin
    e    <= e_next;
    axis <= axis_next;
    side <= side_next;
    miss <= miss_next;
    tmin <= tmin_next;
    tmax <= tmax_next;
    t1   <= t1_next;
    if (emit) begin
      m_tuser <= out_hit;
      m_tdata <= {4'd0, out_dist, out_id};
    end
  end

  // Sequencer over axes and slab sides, then the nearest-hit update.
  always_comb begin
    logic signed [31:0] near_t;
    logic signed [31:0] far_t;
    logic               hit;
    logic               take;
    state_next     = state;
    e_next         = e;
    axis_next      = axis;
    side_next      = side;
    miss_next      = miss;
    tmin_next      = tmin;
    tmax_next      = tmax;
    t1_next        = t1;
    best_dist_next = best_dist;
    best_id_next   = best_id;
    found_next     = found;
    q_pop          = 1'b0;
    div_start      = 1'b0;
    emit           = 1'b0;
    near_t         = (t1 < div_q) ? t1 : div_q;
    far_t          = (t1 < div_q) ? div_q : t1;
    hit            = !miss && !(tmax < 0) && !(tmin > tmax);
    take           = hit && (tmin < best_dist);
    out_hit        = found || take;
    out_id         = take ? e.box_id : (found ? best_id : '0);
    out_dist       = take ? tmin : (found ? best_dist : '0);
    unique case (state)
      rbnh_pkg::S_IDLE: begin
        if (!q_empty) begin
          e_next     = q_head;
          q_pop      = 1'b1;
          tmin_next  = rbnh_pkg::S32_MIN;
          tmax_next  = rbnh_pkg::S32_MAX;
          miss_next  = 1'b0;
          axis_next  = 2'd0;
          side_next  = 1'b0;
          state_next = rbnh_pkg::S_AXIS;
        end
      end
      rbnh_pkg::S_AXIS: begin
        if (dir_cur == '0) begin
          // Ray parallel to this slab: the origin must lie within it.
          if (lo_cur > 0 || hi_cur < 0) miss_next = 1'b1;
          if (axis == 2'd2) state_next = rbnh_pkg::S_DONE;
          else axis_next = axis + 2'd1;
        end else begin
          div_start  = 1'b1;
          state_next = rbnh_pkg::S_WAIT;
        end
      end
      rbnh_pkg::S_WAIT: begin
        if (div_done) begin
          if (!side) begin
            t1_next    = div_q;
            side_next  = 1'b1;
            state_next = rbnh_pkg::S_AXIS;
          end else begin
            if (near_t > tmin) tmin_next = near_t;
            if (far_t < tmax)  tmax_next = far_t;
            side_next = 1'b0;
            if (axis == 2'd2) begin
              state_next = rbnh_pkg::S_DONE;
            end else begin
              axis_next  = axis + 2'd1;
              state_next = rbnh_pkg::S_AXIS;
            end
          end
        end
      end
      rbnh_pkg::S_DONE: begin
        if (!e.last_box) begin
          if (take) begin
            best_dist_next = tmin;
            best_id_next   = e.box_id;
            found_next     = 1'b1;
          end
          state_next = rbnh_pkg::S_IDLE;
        end else if (!m_tvalid || m_tready) begin
          // Last box of the pick: report and start afresh.
          emit           = 1'b1;
          best_dist_next = rbnh_pkg::LIMIT;
          best_id_next   = '0;
          found_next     = 1'b0;
          state_next     = rbnh_pkg::S_IDLE;
        end
      end
      default: state_next = rbnh_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/ray_box_nearest_hit.sv
`timescale 1ns / 1ps
`default_nettype none
// Nearest ray hit over a stream of axis-aligned boxes, slab method, signed
// Q16.16 throughout. Write the ray origin and direction through the
// configuration port while the block is idle, then stream boxes; the box
// marked with tlast closes a pick and yields one result (tuser = hit flag).
// For each axis with a non-zero direction, the box's two slab distances go
// one after the other through a single shared divider. A division is
// started, produces its quotient bit by bit, and its result is then taken;
// a quotient that is seen up front to saturate skips the bit steps. An
// axis with zero direction needs no division. Each box is first fetched
// from the queue and at the end checked against the nearest hit; the last
// box of a pick also waits while an earlier result is still held by the
// sink. A two-entry queue lets the input side take boxes while the back
// end is still dividing.
module ray_box_nearest_hit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wen,
  input  wire logic [2:0]                        cfg_index,
  input  wire logic [31:0]                       cfg_wdata,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // center_x[31:0], center_y[63:32], center_z[95:64], size_x[126:96],
  // size_y[157:127], size_z[188:158], box_id[208:189], zero pad
  input  wire logic [rbnh_pkg::IN_DATA_W-1:0]    s_tdata,
  input  wire logic                              s_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // nearest_id[19:0], nearest_distance[51:20], zero pad
  output logic [rbnh_pkg::OUT_DATA_W-1:0]        m_tdata,
  // hit_found[0]
  output logic                                   m_tuser
);

  logic [2:0][31:0]  origin;
  logic [2:0][31:0]  dir;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  rbnh_pkg::entry_t  q_entry;
  rbnh_pkg::entry_t  q_head;

  // Ray configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
      dir    <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        rbnh_pkg::CFG_ORIGIN_X: origin[0] <= cfg_wdata;
        rbnh_pkg::CFG_ORIGIN_Y: origin[1] <= cfg_wdata;
        rbnh_pkg::CFG_ORIGIN_Z: origin[2] <= cfg_wdata;
        rbnh_pkg::CFG_DIR_X:    dir[0]    <= cfg_wdata;
        rbnh_pkg::CFG_DIR_Y:    dir[1]    <= cfg_wdata;
        rbnh_pkg::CFG_DIR_Z:    dir[2]    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rbnh_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .origin   (origin),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  rbnh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  rbnh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .dir      (dir),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

FILE: sv/rbnh_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ray_box_nearest_hit_macros.svh"
module rbnh_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [rbnh_pkg::OUT_DATA_W-1:0]   m_tdata,
  input wire logic                              m_tuser
);

  // A result waiting on the sink stays offered.
  `RBNH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

  // A pick without a hit reports zero id and zero distance.
  `RBNH_ASSERT_ALWAYS(a_miss_zero, !m_tvalid || m_tuser || m_tdata == '0, "miss result not zero")

  // A hit is always nearer than the starting limit.
  `RBNH_ASSERT_ALWAYS(a_hit_near, !m_tvalid || !m_tuser || $signed(m_tdata[51:20]) < rbnh_pkg::LIMIT, "hit beyond limit")

  // Reset leaves no result pending.
  `RBNH_ASSERT_AFTER_RST(a_rst_idle, !m_tvalid, "result valid after reset")

endmodule

bind ray_box_nearest_hit rbnh_checker u_rbnh_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
